[src/momf_pkg.sv]
// Shared constants and types for the MAD outlier-rejecting mean filter.
// No dependencies; every other file refers to this package by scoped name.
package momf_pkg;

  // group geometry, fixed by the port widths
  localparam int SAMPLE_COUNT = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int LIMIT_BITS   = 6;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 6'd10;

  // middle pair of the sorted group
  localparam int RANK_BITS = $clog2(SAMPLE_COUNT);
  localparam int MID_LO    = (SAMPLE_COUNT - 1) / 2;
  localparam int MID_HI    = SAMPLE_COUNT / 2;

  // datapath widths, all in doubled units where noted
  localparam int MED_BITS    = SAMPLE_BITS + 1;          // median doubled
  localparam int DEV_BITS    = SAMPLE_BITS + 1;          // |2x - m2|
  localparam int DSUM_BITS   = DEV_BITS + 1;             // MAD doubled
  localparam int THR_BITS    = DSUM_BITS + LIMIT_BITS;   // limit * dsum
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(SAMPLE_COUNT);
  localparam int COUNT_BITS  = $clog2(SAMPLE_COUNT + 1);
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_BITS  = RECIP_SHIFT + 1;
  localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [DEV_BITS-1:0]    dev_t;
  typedef logic [MED_BITS-1:0]    med_t;
  typedef logic [RANK_BITS-1:0]   rank_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [PROD_BITS-1:0]   prod_t;

  typedef sample_t [SAMPLE_COUNT-1:0] sample_vec_t;
  typedef dev_t    [SAMPLE_COUNT-1:0] dev_vec_t;
  typedef rank_t   [SAMPLE_COUNT-1:0] rank_vec_t;

endpackage

[src/mad_outlier_mean_filter.sv]
// Top level: MAD outlier-rejecting mean over a group of eight samples.
// Depends on momf_pkg, momf_rank_lane, momf_mid_select and momf_mean_div.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | in_sample_0 .. in_sample_7
//  out     | out_valid/out_stall| out_filtered_mean, out_kept_count,
//          |                    | out_median_doubled
//  cfg     | cfg_we             | cfg_wdata (outlier limit, quarter steps)
//
// One word per cycle while in_stall is low, through the eleven-stage pipeline
// (rank lanes, median merge, deviation, second rank/merge, threshold multiply,
// keep test, sum, reciprocal multiply).
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up under an output stall; in_stall rises only when all full.
// Synchronous active-low reset clears stage valids and sets the limit to 2.5.
module mad_outlier_mean_filter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [15:0]                            in_sample_0,
  input  logic [15:0]                            in_sample_1,
  input  logic [15:0]                            in_sample_2,
  input  logic [15:0]                            in_sample_3,
  input  logic [15:0]                            in_sample_4,
  input  logic [15:0]                            in_sample_5,
  input  logic [15:0]                            in_sample_6,
  input  logic [15:0]                            in_sample_7,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [15:0]                            out_filtered_mean,
  output logic [3:0]                             out_kept_count,
  output logic [16:0]                            out_median_doubled,
  input  logic                                   cfg_we,
  input  logic [momf_pkg::LIMIT_BITS-1:0]        cfg_wdata
);

  localparam int STAGES = 11;

  // control
  logic [STAGES:1] v_r;
  logic [STAGES:1] v_nxt;
  logic [STAGES:1] ld;
  logic [momf_pkg::LIMIT_BITS-1:0] limit_r;

  // payload stages
  momf_pkg::sample_vec_t raw1_r, raw2_r, raw3_r, raw4_r, raw5_r, raw6_r, raw7_r, raw8_r;
  momf_pkg::rank_vec_t   srank_nxt, srank2_r;
  momf_pkg::med_t        m2_nxt, m2_3_r, m2_4_r, m2_5_r, m2_6_r, m2_7_r, m2_8_r, m2_9_r,
                         m2_10_r;
  momf_pkg::dev_vec_t    dev_nxt, dev4_r, dev5_r, dev6_r, dev7_r;
  momf_pkg::rank_vec_t   drank_nxt, drank5_r;
  logic [momf_pkg::DSUM_BITS-1:0] dsum_nxt, dsum6_r;
  logic [momf_pkg::THR_BITS-1:0]  thr_nxt, thr7_r;
  logic [momf_pkg::SAMPLE_COUNT-1:0] keep_nxt, keep8_r;
  momf_pkg::sum_t        sum_nxt, sum9_r;
  momf_pkg::count_t      cnt_nxt, cnt9_r, cnt10_r;
  momf_pkg::prod_t       prod_nxt, prod10_r;
  momf_pkg::sample_t     mean_nxt;
  momf_pkg::sample_t     out_mean_r;
  momf_pkg::count_t      out_cnt_r;
  momf_pkg::med_t        out_med_r;
  momf_pkg::sample_vec_t in_words;

  assign in_words = {in_sample_7, in_sample_6, in_sample_5, in_sample_4,
                     in_sample_3, in_sample_2, in_sample_1, in_sample_0};

  // stage load chain, from the output back to the input
  always_comb begin
    ld[STAGES] = !v_r[STAGES] || !out_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
    v_nxt[1] = ld[1] ? in_valid : v_r[1];
    for (int k = 2; k <= STAGES; k++) begin
      v_nxt[k] = ld[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign in_stall = !ld[1];
  assign out_valid = v_r[STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      limit_r <= momf_pkg::LIMIT_RESET;
    end else begin
      v_r <= v_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // rank lanes for the samples and for their deviations
  for (genvar g = 0; g < momf_pkg::SAMPLE_COUNT; g++) begin : g_lane
    momf_rank_lane #(.VAL_BITS(momf_pkg::SAMPLE_BITS), .LANE(g)) u_srank (
      .vals (raw1_r),
      .rank (srank_nxt[g])
    );
    momf_rank_lane #(.VAL_BITS(momf_pkg::DEV_BITS), .LANE(g)) u_drank (
      .vals (dev4_r),
      .rank (drank_nxt[g])
    );
  end

  // median and MAD merges
  momf_mid_select #(.VAL_BITS(momf_pkg::SAMPLE_BITS)) u_med (
    .vals    (raw2_r),
    .ranks   (srank2_r),
    .mid_sum (m2_nxt)
  );

  momf_mid_select #(.VAL_BITS(momf_pkg::DEV_BITS)) u_mad (
    .vals    (dev5_r),
    .ranks   (drank5_r),
    .mid_sum (dsum_nxt)
  );

  // doubled absolute deviation per lane
  always_comb begin
    momf_pkg::dev_t twice;
    for (int i = 0; i < momf_pkg::SAMPLE_COUNT; i++) begin
      twice = {raw3_r[i], 1'b0};
      dev_nxt[i] = (twice >= m2_3_r) ? (twice - m2_3_r) : (m2_3_r - twice);
    end
  end

  // threshold: limit in quarters times doubled MAD
  assign thr_nxt = momf_pkg::THR_BITS'(limit_r) * momf_pkg::THR_BITS'(dsum6_r);

  // keep test: 8 * dev <= thr
  always_comb begin
    for (int i = 0; i < momf_pkg::SAMPLE_COUNT; i++) begin
      keep_nxt[i] = momf_pkg::THR_BITS'({dev7_r[i], 3'b000}) <= thr7_r;
    end
  end

  // sum and count of kept samples
  always_comb begin
    sum_nxt = '0;
    cnt_nxt = '0;
    for (int i = 0; i < momf_pkg::SAMPLE_COUNT; i++) begin
      if (keep8_r[i]) begin
        sum_nxt = sum_nxt + momf_pkg::SUM_BITS'(raw8_r[i]);
        cnt_nxt = cnt_nxt + momf_pkg::COUNT_BITS'(1);
      end
    end
  end

  momf_mean_div u_div (
    .sum  (sum9_r),
    .cnt  (cnt9_r),
    .prod (prod_nxt)
  );

  // fall back to the floored median when nothing is kept
  assign mean_nxt = (cnt10_r != '0) ? prod10_r[momf_pkg::RECIP_SHIFT +: momf_pkg::SAMPLE_BITS]
                                    : m2_10_r[momf_pkg::MED_BITS-1:1];

  // payload pipeline
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      raw1_r <= in_words;
    end
    if (ld[2]) begin
      raw2_r   <= raw1_r;
      srank2_r <= srank_nxt;
    end
    if (ld[3]) begin
      raw3_r <= raw2_r;
      m2_3_r <= m2_nxt;
    end
    if (ld[4]) begin
      raw4_r <= raw3_r;
      m2_4_r <= m2_3_r;
      dev4_r <= dev_nxt;
    end
    if (ld[5]) begin
      raw5_r   <= raw4_r;
      m2_5_r   <= m2_4_r;
      dev5_r   <= dev4_r;
      drank5_r <= drank_nxt;
    end
    if (ld[6]) begin
      raw6_r  <= raw5_r;
      m2_6_r  <= m2_5_r;
      dev6_r  <= dev5_r;
      dsum6_r <= dsum_nxt;
    end
    if (ld[7]) begin
      raw7_r <= raw6_r;
      m2_7_r <= m2_6_r;
      dev7_r <= dev6_r;
      thr7_r <= thr_nxt;
    end
    if (ld[8]) begin
      raw8_r  <= raw7_r;
      m2_8_r  <= m2_7_r;
      keep8_r <= keep_nxt;
    end
    if (ld[9]) begin
      m2_9_r <= m2_8_r;
      sum9_r <= sum_nxt;
      cnt9_r <= cnt_nxt;
    end
    if (ld[10]) begin
      m2_10_r  <= m2_9_r;
      cnt10_r  <= cnt9_r;
      prod10_r <= prod_nxt;
    end
    if (ld[11]) begin
      out_mean_r <= mean_nxt;
      out_cnt_r  <= cnt10_r;
      out_med_r  <= m2_10_r;
    end
  end

  assign out_filtered_mean  = out_mean_r;
  assign out_kept_count     = out_cnt_r;
  assign out_median_doubled = out_med_r;

endmodule

[src/momf_rank_lane.sv]
// One rank lane: position of its own element in the sorted group.
// Depends on momf_pkg. Ties are broken by lane index so ranks form a permutation.
module momf_rank_lane #(
  parameter int VAL_BITS = 16,
  parameter int LANE     = 0
) (
  input  logic [momf_pkg::SAMPLE_COUNT-1:0][VAL_BITS-1:0] vals,
  output momf_pkg::rank_t                                 rank
);

  // count elements that sort ahead of this one
  always_comb begin
    momf_pkg::rank_t cnt;
    cnt = '0;
    for (int j = 0; j < momf_pkg::SAMPLE_COUNT; j++) begin
      if (j != LANE) begin
        if ((vals[j] < vals[LANE]) || ((vals[j] == vals[LANE]) && (j < LANE))) begin
          cnt = cnt + momf_pkg::RANK_BITS'(1);
        end
      end
    end
    rank = cnt;
  end

endmodule

[src/momf_mid_select.sv]
// Merge stage: picks the two middle-ranked elements and adds them.
// Depends on momf_pkg; takes the ranks produced by the rank lanes.
module momf_mid_select #(
  parameter int VAL_BITS = 16
) (
  input  logic [momf_pkg::SAMPLE_COUNT-1:0][VAL_BITS-1:0] vals,
  input  momf_pkg::rank_vec_t                             ranks,
  output logic [VAL_BITS:0]                               mid_sum
);

  // ranks are a permutation, so each select is one-hot
  always_comb begin
    logic [VAL_BITS-1:0] lo_val;
    logic [VAL_BITS-1:0] hi_val;
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < momf_pkg::SAMPLE_COUNT; i++) begin
      if (ranks[i] == momf_pkg::RANK_BITS'(momf_pkg::MID_LO)) begin
        lo_val = lo_val | vals[i];
      end
      if (ranks[i] == momf_pkg::RANK_BITS'(momf_pkg::MID_HI)) begin
        hi_val = hi_val | vals[i];
      end
    end
    mid_sum = {1'b0, lo_val} + {1'b0, hi_val};
  end

endmodule

[src/momf_mean_div.sv]
// Mean of the kept samples: sum times a reciprocal of the count.
// Depends on momf_pkg. Quotient is exact for every sum that the group can reach.
module momf_mean_div (
  input  momf_pkg::sum_t   sum,
  input  momf_pkg::count_t cnt,
  output momf_pkg::prod_t  prod
);

  // ceil(2^24 / k) for k = 1..8
  function automatic logic [momf_pkg::RECIP_BITS-1:0] recip(input momf_pkg::count_t k);
    logic [momf_pkg::RECIP_BITS-1:0] r;
    case (k)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd8388608;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194304;
      4'd5:    r = 25'd3355444;
      4'd6:    r = 25'd2796203;
      4'd7:    r = 25'd2396746;
      4'd8:    r = 25'd2097152;
      default: r = '0;
    endcase
    return r;
  endfunction

  // quotient sits at bit RECIP_SHIFT of the product
  assign prod = momf_pkg::PROD_BITS'(sum) * momf_pkg::PROD_BITS'(recip(cnt));

endmodule

[dv/tb.sv]
// Self-checking testbench for mad_outlier_mean_filter: directed and random sample groups,
// random stalls on both channels and limit register changes between phases.
// Depends on momf_pkg and the filter RTL only.
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_REPORTS = 10;

  // one result word as the block presents it
  typedef struct packed {
    logic [15:0] mean;
    logic [3:0]  kept;
    logic [16:0] med2;
  } filt_res_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  momf_pkg::sample_vec_t           in_samples = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [15:0]                     out_filtered_mean;
  logic [3:0]                      out_kept_count;
  logic [16:0]                     out_median_doubled;
  logic                            cfg_we = 1'b0;
  logic [momf_pkg::LIMIT_BITS-1:0] cfg_wdata = '0;

  // testbench state
  filt_res_t                       pending_results[$];
  filt_res_t                       oldest;
  logic [momf_pkg::LIMIT_BITS-1:0] active_limit = momf_pkg::LIMIT_RESET;
  int                              send_idle_pct = 15;
  int                              recv_idle_pct = 64;
  logic                            hold_out = 1'b0;
  int                              fail_count = 0;
  int                              groups_sent = 0;
  int                              results_checked = 0;
  int                              none_kept_seen = 0;
  int                              cycle_count = 0;

  mad_outlier_mean_filter uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_0        (in_samples[0]),
    .in_sample_1        (in_samples[1]),
    .in_sample_2        (in_samples[2]),
    .in_sample_3        (in_samples[3]),
    .in_sample_4        (in_samples[4]),
    .in_sample_5        (in_samples[5]),
    .in_sample_6        (in_samples[6]),
    .in_sample_7        (in_samples[7]),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_mean  (out_filtered_mean),
    .out_kept_count     (out_kept_count),
    .out_median_doubled (out_median_doubled),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ascending sort of eight 17-bit values
  function automatic momf_pkg::dev_vec_t sort_up(momf_pkg::dev_vec_t v);
    momf_pkg::dev_t t;
    for (int i = 0; i < momf_pkg::SAMPLE_COUNT - 1; i++)
      for (int j = 0; j < momf_pkg::SAMPLE_COUNT - 1 - i; j++)
        if (v[j] > v[j+1]) begin
          t = v[j];
          v[j] = v[j+1];
          v[j+1] = t;
        end
    return v;
  endfunction

  // median, MAD-scaled keep test and floored mean of kept samples
  function automatic filt_res_t predict_filter(momf_pkg::sample_vec_t s,
                                               logic [momf_pkg::LIMIT_BITS-1:0] lim);
    momf_pkg::dev_vec_t srt;
    momf_pkg::dev_vec_t devs;
    logic [16:0] m2;
    logic [17:0] dsum;
    logic [23:0] thr;
    logic [18:0] sum;
    logic [3:0]  kept;
    logic [18:0] mean;
    filt_res_t   r;
    for (int i = 0; i < momf_pkg::SAMPLE_COUNT; i++) srt[i] = {1'b0, s[i]};
    srt = sort_up(srt);
    m2 = srt[momf_pkg::MID_LO] + srt[momf_pkg::MID_HI];
    for (int i = 0; i < momf_pkg::SAMPLE_COUNT; i++)
      devs[i] = ({s[i], 1'b0} >= m2) ? {s[i], 1'b0} - m2 : m2 - {s[i], 1'b0};
    srt = sort_up(devs);
    dsum = {1'b0, srt[momf_pkg::MID_LO]} + {1'b0, srt[momf_pkg::MID_HI]};
    thr = 24'(lim) * 24'(dsum);
    sum = '0;
    kept = '0;
    for (int i = 0; i < momf_pkg::SAMPLE_COUNT; i++)
      if (24'({devs[i], 3'b000}) <= thr) begin
        sum = sum + 19'(s[i]);
        kept = kept + 4'd1;
      end
    mean = (kept != 4'd0) ? sum / 19'(kept) : 19'(m2 >> 1);
    r.mean = mean[15:0];
    r.kept = kept;
    r.med2 = m2;
    return r;
  endfunction

  function automatic momf_pkg::sample_vec_t make_group(int a0, int a1, int a2, int a3,
                                                       int a4, int a5, int a6, int a7);
    momf_pkg::sample_vec_t g;
    g[0] = a0[15:0]; g[1] = a1[15:0]; g[2] = a2[15:0]; g[3] = a3[15:0];
    g[4] = a4[15:0]; g[5] = a5[15:0]; g[6] = a6[15:0]; g[7] = a7[15:0];
    return g;
  endfunction

  // mostly tight clusters with a few outliers, plus noise and degenerate groups
  function automatic momf_pkg::sample_vec_t random_group();
    momf_pkg::sample_vec_t g;
    int kind;
    int centre;
    int spread;
    int v;
    int outliers;
    kind = $urandom_range(9);
    centre = $urandom_range(65535);
    spread = 1 << $urandom_range(12);
    outliers = $urandom_range(3);
    for (int i = 0; i < momf_pkg::SAMPLE_COUNT; i++) begin
      case (kind)
        6: v = $urandom_range(65535);
        7: v = (centre + ($urandom_range(2) * spread)) % 65536;
        8: v = $urandom_range(15);
        9: v = $urandom_range(1) ? 65535 - $urandom_range(3) : $urandom_range(3);
        default: begin
          v = centre + $urandom_range(2 * spread) - spread;
          if (i < outliers) v = $urandom_range(65535);
        end
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      g[i] = v[15:0];
    end
    // shuffle so outliers land on any lane
    for (int i = momf_pkg::SAMPLE_COUNT - 1; i > 0; i--) begin
      v = $urandom_range(i);
      {g[i], g[v]} = {g[v], g[i]};
    end
    return g;
  endfunction

  // offer one group, hold it until taken, then maybe idle
  task automatic send_group(momf_pkg::sample_vec_t g);
    in_valid <= 1'b1;
    in_samples <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_filter(g, active_limit));
    groups_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [momf_pkg::LIMIT_BITS-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_limit = v;
  endtask

  // receiver stalls: random, or held for a long stretch
  always @(posedge clk) begin
    out_stall <= rst_n && (hold_out || ($urandom_range(99) < recv_idle_pct));
  end

  task automatic report_mismatch(string what, filt_res_t w, filt_res_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s: expected mean %0d kept %0d med2 %0d, got mean %0d kept %0d med2 %0d",
               what, w.mean, w.kept, w.med2, got.mean, got.kept, got.med2);
  endtask

  // compare each result word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0,
                        {out_filtered_mean, out_kept_count, out_median_doubled});
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        if (oldest.kept == 4'd0) none_kept_seen++;
        if (out_filtered_mean !== oldest.mean || out_kept_count !== oldest.kept ||
            out_median_doubled !== oldest.med2)
          report_mismatch("result mismatch", oldest,
                          {out_filtered_mean, out_kept_count, out_median_doubled});
      end
    end
  end

  // corner groups at the reset limit of 2.5
  task automatic test_directed_default_limit();
    send_group(make_group(0, 0, 0, 0, 0, 0, 0, 0));
    send_group(make_group(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535));
    send_group(make_group(100, 100, 100, 60000, 100, 100, 100, 100));
    send_group(make_group(7000, 0, 5000, 1000, 3000, 6000, 2000, 4000));
    send_group(make_group(0, 65535, 0, 65535, 0, 65535, 0, 65535));
    send_group(make_group(0, 10, 0, 10, 0, 10, 0, 10));
    send_group(make_group(500, 499, 500, 9000, 500, 501, 500, 500));
    send_group(make_group(1, 2, 4, 8, 16, 32, 64, 128));
    send_group(make_group(256, 512, 1024, 2048, 4096, 8192, 16384, 32768));
  endtask

  // zero limit, full-scale limit and the keep boundary for a two-level group
  task automatic test_directed_limit_extremes();
    write_limit('0);
    send_group(make_group(0, 0, 0, 0, 10, 10, 10, 10));
    send_group(make_group(100, 100, 100, 60000, 100, 100, 100, 100));
    send_group(make_group(500, 499, 500, 9000, 500, 501, 500, 500));
    send_group(make_group(0, 65535, 0, 65535, 0, 65535, 0, 65535));
    write_limit('1);
    send_group(make_group(100, 100, 100, 60000, 100, 100, 100, 100));
    send_group(make_group(7000, 0, 5000, 1000, 3000, 6000, 2000, 4000));
    send_group(make_group(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535));
    write_limit(6'd3);
    send_group(make_group(0, 65535, 0, 65535, 0, 65535, 0, 65535));
    write_limit(6'd4);
    send_group(make_group(0, 65535, 0, 65535, 0, 65535, 0, 65535));
  endtask

  // long output hold-off fills the pipeline and must stall the input
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(6'd10);
    hold_out <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
    join_none
    repeat (40) send_group(random_group());
    wait_drained();
  endtask

  // random groups over three stall mixes and six limit settings
  task automatic test_random_traffic();
    logic [momf_pkg::LIMIT_BITS-1:0] lims[6];
    lims[0] = 6'd10;
    lims[1] = '1;
    lims[2] = '0;
    lims[3] = 6'($urandom_range(1, 62));
    lims[4] = 6'd4;
    lims[5] = 6'($urandom_range(1, 62));
    for (int seg = 0; seg < 6; seg++) begin
      write_limit(lims[seg]);
      send_idle_pct = (seg < 2) ? 15 : (seg < 4) ? 64 : 0;
      recv_idle_pct = (seg < 2) ? 64 : (seg < 4) ? 15 : 0;
      repeat (130) send_group(random_group());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_default_limit();
    test_directed_limit_extremes();
    test_output_holdoff();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d groups, checked %0d results (%0d with no sample kept)",
             groups_sent, results_checked, none_kept_seen);
    $display("limits 0 to 63 exercised, input and output stall mixes plus a long hold-off");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_results.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
